/* rtl/core/prc_pkg.sv */
// Shared types, widths and register indices for the proportional-resonant controller.
// Used by every module under rtl/core; has no dependencies of its own.
`default_nettype none

package prc_pkg;

    localparam int COEF_W          = 24;   // coefficient width, signed
    localparam int COEF_FRAC_BITS  = 20;   // fractional bits of the coefficients
    localparam int LIMIT_W         = 15;   // saturation magnitude width, unsigned
    localparam int DRV_W           = LIMIT_W + 1;  // saturated drive always fits here
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = COEF_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_A1    = 3'd3,
        REG_A2    = 3'd4,
        REG_LIMIT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0]  b0;
        logic signed [COEF_W-1:0]  b1;
        logic signed [COEF_W-1:0]  b2;
        logic signed [COEF_W-1:0]  a1;
        logic signed [COEF_W-1:0]  a2;
        logic        [LIMIT_W-1:0] limit;
    } t_coefs;

    // Load strobes of the four pipeline registers.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

    // Width of one coefficient product: covers both error and drive history.
    function automatic int prod_w(input int sample_bits);
        int mw;
        mw = (sample_bits + 1 > DRV_W) ? sample_bits + 1 : DRV_W;
        return COEF_W + mw;
    endfunction

    // Accumulator width: five products summed without overflow.
    function automatic int acc_w(input int sample_bits);
        return prod_w(sample_bits) + 3;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pr_controller_clamped_top.sv */
// Proportional-resonant controller (biquad form) with symmetric drive clamp.
// Each word is registered as input samples, then products, sum and result.
// Throughput: one word per cycle unless the output stalls; the drive recursion (a1
// product, sum, scale and clamp) closes within the single result-register stage.
// Reset (synchronous, active low): empties the pipeline, zeroes error and drive
// history and all coefficients, and sets the drive limit to 32767.
`default_nettype none

module pr_controller_clamped_top #(
    parameter int SAMPLE_BITS = prc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [prc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [prc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, low to high: setpoint, feedback, zero pad
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata, low to high: drive, error_out, zero pad
    output logic [((2*SAMPLE_BITS+8)/8)*8-1:0]     m_axis_tdata
);

    localparam int OUT_TD_W = ((2*SAMPLE_BITS+8)/8)*8;
    localparam int ACC_W    = prc_pkg::acc_w(SAMPLE_BITS);

    prc_pkg::t_coefs    coefs;
    prc_pkg::t_pipe_ctl ctl;

    // stage valid bits; stage 4 is the result register
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [ACC_W-1:0]       ff;
    logic signed [SAMPLE_BITS:0]   err_s3, err_out;
    logic signed [SAMPLE_BITS-1:0] drive;

    // Always taken; the host must write only while no word is in flight (unchecked).
    assign o_cfg_ready = 1'b1;

    prc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_coefs    (coefs)
    );

    // A stage can load when it is empty or its word moves on this cycle;
    // bubbles collapse, so a stalled output still lets earlier stages fill.
    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ctl.ld1 = s_axis_tvalid && rdy1;
    assign ctl.ld2 = r_v1 && rdy2;
    assign ctl.ld3 = r_v2 && rdy3;
    assign ctl.ld4 = r_v3 && rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            // set on load, drop when the word moves downstream
            r_v1 <= ctl.ld1 || (r_v1 && !ctl.ld2);
            r_v2 <= ctl.ld2 || (r_v2 && !ctl.ld3);
            r_v3 <= ctl.ld3 || (r_v3 && !ctl.ld4);
            r_v4 <= ctl.ld4 || (r_v4 && !m_axis_tready);
        end
    end

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_v4;

    // Stages 1-3: input samples, error and numerator products, feedforward sum.
    prc_ff #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ff (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_coefs    (coefs),
        .i_setpoint ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_feedback ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .o_ff       (ff),
        .o_err      (err_s3)
    );

    // Stage 4: drive recursion, clamp and result register.
    prc_fb #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_coefs (coefs),
        .i_ff    (ff),
        .i_err   (err_s3),
        .o_drive (drive),
        .o_err   (err_out)
    );

    assign m_axis_tdata = OUT_TD_W'({err_out, drive});

endmodule

`default_nettype wire

/* rtl/core/prc_cfg_regs.sv */
// Configuration register file: coefficients and drive limit.
// Depends on prc_pkg for register indices and the coefficient struct.
`default_nettype none

module prc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [prc_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  wire logic [prc_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output prc_pkg::t_coefs                       o_coefs
);

    prc_pkg::t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0    <= '0;
            r_coefs.b1    <= '0;
            r_coefs.b2    <= '0;
            r_coefs.a1    <= '0;
            r_coefs.a2    <= '0;
            r_coefs.limit <= prc_pkg::LIMIT_RESET;
        end else if (i_wr_en) begin
            unique case (prc_pkg::t_cfg_idx'(i_wr_index))
                prc_pkg::REG_B0:    r_coefs.b0    <= $signed(i_wr_data);
                prc_pkg::REG_B1:    r_coefs.b1    <= $signed(i_wr_data);
                prc_pkg::REG_B2:    r_coefs.b2    <= $signed(i_wr_data);
                prc_pkg::REG_A1:    r_coefs.a1    <= $signed(i_wr_data);
                prc_pkg::REG_A2:    r_coefs.a2    <= $signed(i_wr_data);
                prc_pkg::REG_LIMIT: r_coefs.limit <= i_wr_data[prc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

/* rtl/core/prc_ff.sv */
// Feedforward stages: error, error history, numerator products and their sum.
// Depends on prc_pkg; feeds prc_fb.
`default_nettype none

module prc_ff #(
    parameter int SAMPLE_BITS = prc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire prc_pkg::t_pipe_ctl                        i_ctl,
    input  wire prc_pkg::t_coefs                           i_coefs,
    input  wire logic signed [SAMPLE_BITS-1:0]             i_setpoint,
    input  wire logic signed [SAMPLE_BITS-1:0]             i_feedback,
    output logic signed [prc_pkg::acc_w(SAMPLE_BITS)-1:0]  o_ff,
    output logic signed [SAMPLE_BITS:0]                    o_err
);

    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = prc_pkg::prod_w(SAMPLE_BITS);
    localparam int ACC_W  = prc_pkg::acc_w(SAMPLE_BITS);

    // stage 1: input samples
    logic signed [SAMPLE_BITS-1:0] r_sp, r_fb;
    // error history, advanced as each word leaves stage 1
    logic signed [ERR_W-1:0]       r_e1, r_e2;
    // stage 2: error and the three numerator products
    logic signed [ERR_W-1:0]       r_e_s2;
    logic signed [PROD_W-1:0]      r_pb0, r_pb1, r_pb2;
    // stage 3: feedforward sum
    logic signed [ERR_W-1:0]       r_e_s3;
    logic signed [ACC_W-1:0]       r_ff;

    logic signed [ERR_W-1:0]       err;
    logic signed [PROD_W-1:0]      n_pb0, n_pb1, n_pb2;

    assign err   = ERR_W'(r_sp) - ERR_W'(r_fb);
    assign n_pb0 = PROD_W'(i_coefs.b0) * PROD_W'(err);
    assign n_pb1 = PROD_W'(i_coefs.b1) * PROD_W'(r_e1);
    assign n_pb2 = PROD_W'(i_coefs.b2) * PROD_W'(r_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else if (i_ctl.ld2) begin
            r_e1 <= err;
            r_e2 <= r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_sp <= i_setpoint;
            r_fb <= i_feedback;
        end
        if (i_ctl.ld2) begin
            r_e_s2 <= err;
            r_pb0  <= n_pb0;
            r_pb1  <= n_pb1;
            r_pb2  <= n_pb2;
        end
        if (i_ctl.ld3) begin
            r_e_s3 <= r_e_s2;
            r_ff   <= ACC_W'(r_pb0) + ACC_W'(r_pb1) + ACC_W'(r_pb2);
        end
    end

    assign o_ff  = r_ff;
    assign o_err = r_e_s3;

endmodule

`default_nettype wire

/* rtl/core/prc_fb.sv */
// Feedback stage: denominator terms, scaling, saturation, drive history, result register.
// Depends on prc_pkg; takes the feedforward sum from prc_ff.
`default_nettype none

module prc_fb #(
    parameter int SAMPLE_BITS = prc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire prc_pkg::t_pipe_ctl                             i_ctl,
    input  wire prc_pkg::t_coefs                                i_coefs,
    input  wire logic signed [prc_pkg::acc_w(SAMPLE_BITS)-1:0]  i_ff,
    input  wire logic signed [SAMPLE_BITS:0]                    i_err,
    output logic signed [SAMPLE_BITS-1:0]                       o_drive,
    output logic signed [SAMPLE_BITS:0]                         o_err
);

    localparam int DRV_W  = prc_pkg::DRV_W;
    localparam int PROD_W = prc_pkg::prod_w(SAMPLE_BITS);
    localparam int ACC_W  = prc_pkg::acc_w(SAMPLE_BITS);

    logic signed [DRV_W-1:0]       r_u1, r_u2;
    logic signed [PROD_W-1:0]      r_pa2;
    logic signed [SAMPLE_BITS-1:0] r_drive;
    logic signed [SAMPLE_BITS:0]   r_err;

    logic signed [PROD_W-1:0]      pa1, n_pa2;
    logic signed [ACC_W-1:0]       acc, scaled, lim, neg_lim, u_sat;

    // a2 term is one step behind: keep it refreshed every cycle so it follows
    // both the drive history and any coefficient rewrite.
    assign n_pa2 = PROD_W'(i_coefs.a2) * PROD_W'(i_ctl.ld4 ? r_u1 : r_u2);
    assign pa1   = PROD_W'(i_coefs.a1) * PROD_W'(r_u1);

    assign acc     = i_ff - ACC_W'(pa1) - ACC_W'(r_pa2);
    assign scaled  = acc >>> prc_pkg::COEF_FRAC_BITS;
    assign lim     = $signed(ACC_W'({1'b0, i_coefs.limit}));
    assign neg_lim = -lim;

    always_comb begin
        if (scaled <= neg_lim) begin
            u_sat = neg_lim;
        end else if (scaled >= lim) begin
            u_sat = lim;
        end else begin
            u_sat = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1  <= '0;
            r_u2  <= '0;
            r_pa2 <= '0;
        end else begin
            r_pa2 <= n_pa2;
            if (i_ctl.ld4) begin
                r_u1 <= u_sat[DRV_W-1:0];
                r_u2 <= r_u1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_drive <= u_sat[SAMPLE_BITS-1:0];
            r_err   <= i_err;
        end
    end

    assign o_drive = r_drive;
    assign o_err   = r_err;

endmodule

`default_nettype wire
